FILE: hw/rtl/c2s_pkg.sv
// Shared constants for the cartesian-to-spherical core: CORDIC arctangent
// table, angle formats and limits. No dependencies.
`default_nettype none
package c2s_pkg;
	localparam int GUARD_BITS = 16;
	localparam int ACC_W      = 36;
	localparam int ANG_W      = ACC_W - 14;
	localparam int TABLE_LEN  = 24;
	localparam int RND_SHIFT  = 14;

	localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ACC_W-1:0] ROUND_Q30   = 36'sd8192;
	localparam logic signed [ANG_W-1:0] PI_Q16      = 22'sd205887;
	localparam logic [23:0]             RADIUS_MAX  = 24'hFFFFFF;
	localparam logic [23:0]             THR_RESET   = 24'd1;

	typedef logic [31:0] atan_tab_t [TABLE_LEN];

	localparam atan_tab_t ATAN_Q30 = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128
	};
endpackage
`default_nettype wire

FILE: hw/rtl/c2s_if.sv
// Valid/ready channels for the point request and the spherical result.
// Depends on nothing.
`default_nettype none
interface c2s_point_if #(parameter int COORD_WIDTH = 24);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;
	logic signed [COORD_WIDTH-1:0] z_coord;
	modport source (output valid, x_coord, y_coord, z_coord, input ready);
	modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface c2s_sph_if;
	logic               valid;
	logic               ready;
	logic        [23:0] radius;
	logic signed [18:0] azimuth;
	logic        [17:0] polar_angle;
	modport source (output valid, radius, azimuth, polar_angle, input ready);
	modport sink   (input valid, radius, azimuth, polar_angle, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/c2s_isqrt.sv
// Pipelined floor square root, one root bit per register stage.
// Advances only when en is high. No package use.
`default_nettype none
module c2s_isqrt #(
	parameter int WIDTH = 24
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [2*WIDTH-1:0] radicand,
	output logic      [WIDTH-1:0]   root
);
	localparam int SW = 2 * WIDTH;

	logic [SW-1:0] rem_s  [0:WIDTH];
	logic [SW-1:0] root_s [0:WIDTH];

	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;

	for (genvar i = 0; i < WIDTH; i++) begin : g_step
		localparam logic [SW:0] BIT = {{SW{1'b0}}, 1'b1} << (SW - 2 - 2 * i);
		logic [SW:0] trial;
		logic        take;
		assign trial = {1'b0, root_s[i]} + BIT;
		assign take  = {1'b0, rem_s[i]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					rem_s[i+1]  <= rem_s[i] - trial[SW-1:0];
					root_s[i+1] <= (root_s[i] >> 1) + BIT[SW-1:0];
				end else begin
					rem_s[i+1]  <= rem_s[i];
					root_s[i+1] <= root_s[i] >> 1;
				end
			end
		end
	end

	assign root = root_s[WIDTH][WIDTH-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/c2s_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(num, den) in Q.16 radians.
// The input rotation, the rotation stages and the output register advance only when en is high. Uses c2s_pkg.
`default_nettype none
module c2s_cordic #(
	parameter int IN_W   = 25,
	parameter int STAGES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [IN_W-1:0]        num,
	input  wire logic signed [IN_W-1:0]        den,
	output logic signed [c2s_pkg::ANG_W-1:0]   angle
);
	localparam int CW = IN_W + c2s_pkg::GUARD_BITS + 3;
	localparam int AW = c2s_pkg::ACC_W;

	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [AW-1:0] acc_s [0:STAGES];
	logic                 zero_s [0:STAGES];
	logic signed [CW-1:0] xin, yin;
	logic signed [AW-1:0] rnd;

	assign xin = {{(CW-IN_W-c2s_pkg::GUARD_BITS){den[IN_W-1]}}, den,
		{c2s_pkg::GUARD_BITS{1'b0}}};
	assign yin = {{(CW-IN_W-c2s_pkg::GUARD_BITS){num[IN_W-1]}}, num,
		{c2s_pkg::GUARD_BITS{1'b0}}};

	// left half plane: turn by 90 degrees first
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (num == '0) && (den == '0);
			if (xin < 0 && yin >= 0) begin
				x_s[0] <= yin;  y_s[0] <= -xin; acc_s[0] <= c2s_pkg::HALF_PI_Q30;
			end else if (xin < 0) begin
				x_s[0] <= -yin; y_s[0] <= xin;  acc_s[0] <= -c2s_pkg::HALF_PI_Q30;
			end else begin
				x_s[0] <= xin;  y_s[0] <= yin;  acc_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [AW-1:0] ATN =
			AW'(c2s_pkg::ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] + ATN;
				end else begin
					x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] - ATN;
				end
			end
		end
	end

	assign rnd = (acc_s[STAGES] + c2s_pkg::ROUND_Q30) >>> c2s_pkg::RND_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= zero_s[STAGES] ? '0 : rnd[c2s_pkg::ANG_W-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/cartesian_to_spherical_core.sv
// Converts a stream of 3D points (signed Q.16, y up) to radius, azimuth
// atan2(x, z) and polar angle from +y. Fully pipelined: one point per cycle
// while the result side is not stalled. Steps: squares, sums, one stage per
// root bit in the square roots, then the CORDIC passes and the clamp.
// A stall on the result side holds the whole pipeline. Radius below the
// threshold register (reset 1) gives zero angles. Depends on c2s_pkg,
// c2s_if, c2s_isqrt and c2s_cordic.
`default_nettype none
module cartesian_to_spherical_core #(
	parameter int COORD_WIDTH   = 24,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_wdata,
	c2s_point_if.sink        point,
	c2s_sph_if.source        result
);
	localparam int W   = COORD_WIDTH;
	localparam int SW  = 2 * W;
	localparam int CLT = CORDIC_STAGES + 2;
	localparam int L   = 2 + W + CLT;
	localparam int AW  = c2s_pkg::ANG_W;

	logic en;
	logic [L-1:0] vld_q;
	logic [23:0]  thr_q;

	assign en          = !result.valid || result.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= c2s_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			result.valid <= 1'b0;
		end else if (en) begin
			vld_q        <= {vld_q[L-2:0], point.valid};
			result.valid <= vld_q[L-1];
		end
	end

	// stage 1: squares
	logic [W-1:0]  mx, my, mz;
	logic [SW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [W-1:0] x_s1, y_s1, z_s1;
	assign mx = point.x_coord[W-1] ? W'(-point.x_coord) : point.x_coord;
	assign my = point.y_coord[W-1] ? W'(-point.y_coord) : point.y_coord;
	assign mz = point.z_coord[W-1] ? W'(-point.z_coord) : point.z_coord;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= SW'(mx) * SW'(mx);
			sqy_s1 <= SW'(my) * SW'(my);
			sqz_s1 <= SW'(mz) * SW'(mz);
			x_s1   <= point.x_coord;
			y_s1   <= point.y_coord;
			z_s1   <= point.z_coord;
		end
	end

	// stage 2: sums
	logic [SW-1:0] zx2_s2, r2_s2;
	logic signed [W-1:0] xd_s [0:W];
	logic signed [W-1:0] yd_s [0:W];
	logic signed [W-1:0] zd_s [0:W];
	always_ff @(posedge clk) begin
		if (en) begin
			zx2_s2  <= sqz_s1 + sqx_s1;
			r2_s2   <= sqz_s1 + sqx_s1 + sqy_s1;
			xd_s[0] <= x_s1;
			yd_s[0] <= y_s1;
			zd_s[0] <= z_s1;
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				xd_s[i+1] <= xd_s[i];
				yd_s[i+1] <= yd_s[i];
				zd_s[i+1] <= zd_s[i];
			end
		end
	end

	logic [W-1:0] rad_root, zx_root;
	c2s_isqrt #(.WIDTH(W)) u_sqrt_r  (.clk, .en, .radicand(r2_s2),  .root(rad_root));
	c2s_isqrt #(.WIDTH(W)) u_sqrt_zx (.clk, .en, .radicand(zx2_s2), .root(zx_root));

	logic signed [AW-1:0] az_ang, pol_ang;
	c2s_cordic #(.IN_W(W + 1), .STAGES(CORDIC_STAGES)) u_az (
		.clk, .en,
		.num  ({xd_s[W][W-1], xd_s[W]}),
		.den  ({zd_s[W][W-1], zd_s[W]}),
		.angle(az_ang)
	);
	c2s_cordic #(.IN_W(W + 1), .STAGES(CORDIC_STAGES)) u_pol (
		.clk, .en,
		.num  ({1'b0, zx_root}),
		.den  ({yd_s[W][W-1], yd_s[W]}),
		.angle(pol_ang)
	);

	logic [W-1:0] rd_s [0:CLT];
	assign rd_s[0] = rad_root;
	for (genvar i = 0; i < CLT; i++) begin : g_rad
		always_ff @(posedge clk) begin
			if (en) begin
				rd_s[i+1] <= rd_s[i];
			end
		end
	end

	// final stage: threshold, clamps, radius saturation
	logic [32:0] rad_ext;
	logic        near_zero;
	logic signed [AW-1:0] az_c, pol_c;
	assign rad_ext   = 33'(rd_s[CLT]);
	assign near_zero = rad_ext < 33'(thr_q);

	always_comb begin
		az_c  = az_ang;
		pol_c = pol_ang;
		if (az_ang > c2s_pkg::PI_Q16) az_c = c2s_pkg::PI_Q16;
		if (az_ang < -c2s_pkg::PI_Q16) az_c = -c2s_pkg::PI_Q16;
		if (pol_ang > c2s_pkg::PI_Q16) pol_c = c2s_pkg::PI_Q16;
		if (pol_ang < 0) pol_c = '0;
		if (near_zero) begin
			az_c  = '0;
			pol_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.radius      <= (rad_ext > 33'(c2s_pkg::RADIUS_MAX)) ?
				c2s_pkg::RADIUS_MAX : rad_ext[23:0];
			result.azimuth     <= az_c[18:0];
			result.polar_angle <= pol_c[17:0];
		end
	end

	a_az_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.azimuth <= 19'sd205887) &&
		(result.azimuth >= -19'sd205887))
		else $error("azimuth out of range");
	a_pol_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.polar_angle <= 18'd205887)
		else $error("polar angle out of range");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> point.ready)
		else $error("request stalled with empty output");
endmodule
`default_nettype wire
